// File: src/fptpc_pkg.sv
// Package for the frame period tracker with phase correction.
// Holds the register indexes, window constants and the averaging update struct.
// Depends on nothing; used by fptpc_avg and the top level.
package fptpc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;

    // Acceptance windows around the target period, in microseconds.
    localparam logic signed [17:0] SEED_WINDOW   = 18'sd100;
    localparam logic signed [17:0] UPDATE_WINDOW = 18'sd30;

    // Number of ring samples that form the expected time.
    localparam int unsigned SAMPLE_COUNT = 4;
    localparam int unsigned SAMPLE_BITS  = $clog2(SAMPLE_COUNT);

    // Averaging state after one frame time has been applied.
    typedef struct packed {
        logic        gap;      // frame time exceeded twice the target
        logic        seeded;   // average has been seeded
        logic        full;     // ring full after any gap clear
        logic        corr;     // a phase correction is to be computed
        logic [31:0] scaled;   // scaled average
        logic [15:0] average;  // reported average frame time
    } t_avg_next;

endpackage

// File: src/fptpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fptpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/fptpc_avg.sv
// Frame time, gap detection and leaky average seed/update for one trigger.
// Depends on fptpc_pkg for the window constants and the t_avg_next struct.
module fptpc_avg #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic [31:0]           i_time,
    input  logic [31:0]           i_prev_time,
    input  logic [15:0]           i_target,
    input  logic                  i_seeded,
    input  logic                  i_full,
    input  logic [31:0]           i_scaled,
    input  logic [15:0]           i_average,
    output fptpc_pkg::t_avg_next  o_next
);

    localparam int SH = $clog2(HISTORY_DEPTH);

    logic [31:0]        w_diff;
    logic [15:0]        w_ft;
    logic               w_gap;
    logic               w_seeded0;
    logic               w_full0;
    logic [31:0]        w_scaled0;
    logic [15:0]        w_average0;
    logic [31:0]        w_ns;
    logic [15:0]        w_na;
    logic signed [17:0] w_tgt;
    logic signed [17:0] w_na_s;
    logic signed [17:0] w_ft_s;
    logic               w_no_target;
    logic               w_upd_ok;
    logic               w_seed_ok;

    // Frame time and the gap test against twice the target.
    assign w_diff = i_time - i_prev_time;
    assign w_ft   = w_diff[15:0];
    assign w_gap  = {1'b0, w_ft} > {i_target, 1'b0};

    // A gap clears the averaging state before anything else is applied.
    assign w_seeded0  = i_seeded & ~w_gap;
    assign w_full0    = i_full & ~w_gap;
    assign w_scaled0  = w_gap ? 32'd0 : i_scaled;
    assign w_average0 = w_gap ? 16'd0 : i_average;

    // Candidate leaky average.
    assign w_ns = w_scaled0 - (w_scaled0 >> SH) + {16'd0, w_ft};
    assign w_na = w_ns[SH +: 16];

    // Window checks in signed arithmetic so the low end may go negative.
    assign w_tgt       = $signed({2'b00, i_target});
    assign w_na_s      = $signed({2'b00, w_na});
    assign w_ft_s      = $signed({2'b00, w_ft});
    assign w_no_target = (i_target == 16'd0);
    assign w_upd_ok    = w_no_target || !w_full0 ||
                         ((w_na_s >= w_tgt - fptpc_pkg::UPDATE_WINDOW) &&
                          (w_na_s <= w_tgt + fptpc_pkg::UPDATE_WINDOW));
    assign w_seed_ok   = w_no_target ||
                         ((w_ft_s >= w_tgt - fptpc_pkg::SEED_WINDOW) &&
                          (w_ft_s <= w_tgt + fptpc_pkg::SEED_WINDOW));

    // Seed or update selection.
    always_comb begin
        o_next.gap     = w_gap;
        o_next.full    = w_full0;
        o_next.seeded  = w_seeded0;
        o_next.corr    = 1'b0;
        o_next.scaled  = w_scaled0;
        o_next.average = w_average0;
        if (w_seeded0) begin
            o_next.corr = w_full0;
            if (w_upd_ok) begin
                o_next.scaled  = w_ns;
                o_next.average = w_na;
            end
        end else if (w_seed_ok) begin
            o_next.scaled = {16'd0, w_ft} << SH;
            o_next.seeded = 1'b1;
        end
    end

endmodule

// File: src/frame_period_tracker_phase_correction.sv
// Top level of the frame period tracker with phase correction.
// Depends on fptpc_pkg, fptpc_avg and fptpc_ram (timestamp ring).
//
//  Channel   | Signals                                  | Direction
//  ----------+------------------------------------------+----------
//  cfg write | i_cfg_valid/o_cfg_ready, index, data     | in
//  triggers  | i_s_tvalid/o_s_tready, i_s_tdata         | in
//  results   | o_m_tvalid/i_m_tready, o_m_tdata         | out
//
// An ignored or first trigger goes from the calculation step straight to the
// result register; a processed request passes the ring write step first, and
// one that computes a phase correction also the four sequential reads of the
// timestamp ring through its single read port. The input is ready again once
// the result is loaded, so a request is only taken when the last is through.
// Reset clears all control and averaging state; the ring needs no clearing,
// as its read data is only used once every entry has been written since the last clear.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits for the register before its own result is loaded.
module frame_period_tracker_phase_correction #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Trigger stream. tdata: [31:0] timestamp_us.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    // Result stream. tdata: [15:0] average_frame_time, [31:16] delay_adjustment,
    // [32] average_valid, [33] history_full, [39:34] zero.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic        r_enable;
    logic [15:0] r_target;
    logic [31:0] r_time;
    logic [31:0] r_prev_time, n_prev_time;
    logic        r_prev_valid, n_prev_valid;
    logic        r_seeded, n_seeded;
    logic        r_full, n_full;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0] r_scaled, n_scaled;
    logic [15:0] r_average, n_average;
    logic [15:0] r_phase, n_phase;
    logic        r_proc, n_proc;
    logic        r_corr, n_corr;
    logic [fptpc_pkg::SAMPLE_BITS-1:0] r_k, n_k;
    logic [AW-1:0] r_p, n_p;
    logic [31:0] r_acc, n_acc;
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;

    fptpc_pkg::t_avg_next w_next;
    logic [AW-1:0] w_step;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_en;
    logic          w_wr_en;
    logic [31:0]   w_rd_data;
    logic [31:0]   w_sum;
    logic [31:0]   w_err_full;
    logic [15:0]   w_err;
    logic [15:0]   w_adj;
    logic          w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Frame time and averaging update.
    fptpc_avg #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_avg (
        .i_time      (r_time),
        .i_prev_time (r_prev_time),
        .i_target    (r_target),
        .i_seeded    (r_seeded),
        .i_full      (r_full),
        .i_scaled    (r_scaled),
        .i_average   (r_average),
        .o_next      (w_next)
    );

    // Ring addressing: the oldest entry, then half, a quarter and an eighth further on.
    assign w_step    = AW'(HISTORY_DEPTH / 2) >> r_k;
    assign w_rd_addr = (r_state == S_CALC) ? r_idx : r_p + w_step;
    assign w_rd_en   = (r_state == S_CALC) || (r_state == S_ACC);
    assign w_wr_en   = (r_state == S_WR) && r_proc;

    fptpc_ram #(
        .WIDTH(32),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_time),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Expected time accumulation and the fifteen-sixteenths correction.
    assign w_sum      = w_rd_data + (r_scaled >> r_k);
    assign w_err_full = r_acc - r_time;
    assign w_err      = w_err_full[15:0];
    assign w_adj      = w_err - 16'($signed(w_err) >>> 4);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Sequencer and datapath next state.
    always_comb begin
        n_state      = r_state;
        n_prev_time  = r_prev_time;
        n_prev_valid = r_prev_valid;
        n_seeded     = r_seeded;
        n_full       = r_full;
        n_idx        = r_idx;
        n_scaled     = r_scaled;
        n_average    = r_average;
        n_phase      = r_phase;
        n_proc       = r_proc;
        n_corr       = r_corr;
        n_k          = r_k;
        n_p          = r_p;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_proc = 1'b0;
                n_corr = 1'b0;
                n_k    = '0;
                n_p    = r_idx;
                n_acc  = 32'd0;
                n_state = S_OUT;
                if (r_enable) begin
                    n_prev_time  = r_time;
                    n_prev_valid = 1'b1;
                    if (r_prev_valid) begin
                        n_proc    = 1'b1;
                        n_corr    = w_next.corr;
                        n_seeded  = w_next.seeded;
                        n_full    = w_next.full;
                        n_scaled  = w_next.scaled;
                        n_average = w_next.average;
                        if (w_next.gap) begin
                            n_idx = '0;
                        end
                        n_state = w_next.corr ? S_ACC : S_WR;
                    end
                end
            end
            S_ACC: begin
                n_acc = r_acc + (w_sum >> 2);
                n_p   = r_p + w_step;
                n_k   = r_k + 1'b1;
                if (r_k == fptpc_pkg::SAMPLE_BITS'(fptpc_pkg::SAMPLE_COUNT - 1)) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_full = 1'b1;
                end
                if (r_corr) begin
                    n_phase = w_adj;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_full, r_seeded, r_phase, r_average};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and averaging state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_enable     <= 1'b0;
            r_target     <= 16'd0;
            r_prev_time  <= 32'd0;
            r_prev_valid <= 1'b0;
            r_seeded     <= 1'b0;
            r_full       <= 1'b0;
            r_idx        <= '0;
            r_scaled     <= 32'd0;
            r_average    <= 16'd0;
            r_phase      <= 16'd0;
            r_proc       <= 1'b0;
            r_corr       <= 1'b0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_time  <= n_prev_time;
            r_prev_valid <= n_prev_valid;
            r_seeded     <= n_seeded;
            r_full       <= n_full;
            r_idx        <= n_idx;
            r_scaled     <= n_scaled;
            r_average    <= n_average;
            r_phase      <= n_phase;
            r_proc       <= n_proc;
            r_corr       <= n_corr;
            r_k          <= n_k;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fptpc_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    fptpc_pkg::CFG_TARGET: r_target <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_time <= i_s_tdata;
        end
        r_p        <= n_p;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    // An accepted request always starts with the calculation step.
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CALC))
        else $error("accepted request did not enter the calculation step");

    // Ring reads for a correction only happen with a seeded average and full ring.
    a_acc_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_seeded && r_full && r_corr))
        else $error("ring read without a seeded average and full ring");

    // The last sample moves the sequencer on to the ring write.
    a_acc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACC) &&
         (r_k == fptpc_pkg::SAMPLE_BITS'(fptpc_pkg::SAMPLE_COUNT - 1)))
        |=> (r_state == S_WR))
        else $error("sample accumulation did not end after the last sample");
`endif

endmodule
